// ===== rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int unsigned REQ_W         = 3;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned HALF_W        = 8;
    localparam int unsigned BIT_CNT_W     = 4;
    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam int unsigned S_TDATA_W     = 16;
    localparam int unsigned S_TUSER_W     = 3;
    localparam int unsigned M_TDATA_W     = 16;

    localparam logic [HALF_W-1:0]    HALF_PERIOD_RESET = 8'd10;
    localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE     = 4'd8;

    typedef enum logic [REQ_W-1:0] {
        REQ_NONE     = 3'd0,
        REQ_START    = 3'd1,
        REQ_STOP     = 3'd2,
        REQ_WRITE    = 3'd3,
        REQ_READ     = 3'd4,
        REQ_WAIT_ACK = 3'd5
    } t_req;

    typedef struct packed {
        t_req              req;
        logic [BYTE_W-1:0] tx_byte;
        logic              send_ack;
        logic              sda_sample;
    } t_cmd;

    typedef enum logic [11:0] {
        PH_IDLE       = 12'b0000_0000_0001,
        PH_START_HI   = 12'b0000_0000_0010,
        PH_START_HOLD = 12'b0000_0000_0100,
        PH_STOP_LOW   = 12'b0000_0000_1000,
        PH_STOP_HI    = 12'b0000_0001_0000,
        PH_WR_LOW     = 12'b0000_0010_0000,
        PH_WR_HIGH    = 12'b0000_0100_0000,
        PH_RD_LOW     = 12'b0000_1000_0000,
        PH_RD_HIGH    = 12'b0001_0000_0000,
        PH_ACK_LOW    = 12'b0010_0000_0000,
        PH_ACK_HIGH   = 12'b0100_0000_0000,
        PH_WAIT_ACK   = 12'b1000_0000_0000
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              cmd_done;
        logic              busy_res;
        logic              sda_level;
        logic              scl_level;
    } t_res;

endpackage

// ===== rtl/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// i2cm_front
// Takes tick items from the input stream and classifies the request code.
// ----------------------------------------------------------------------------
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    input  logic                 i_q_full,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    t_req req;

    always_comb begin
        case (s_axis_tuser)
            REQ_START:    req = REQ_START;
            REQ_STOP:     req = REQ_STOP;
            REQ_WRITE:    req = REQ_WRITE;
            REQ_READ:     req = REQ_READ;
            REQ_WAIT_ACK: req = REQ_WAIT_ACK;
            default:      req = REQ_NONE;
        endcase
    end

    assign s_axis_tready    = !i_q_full;
    assign o_push           = s_axis_tvalid && !i_q_full;
    assign o_cmd.req        = req;
    assign o_cmd.tx_byte    = s_axis_tdata[BYTE_W-1:0];
    assign o_cmd.send_ack   = s_axis_tdata[BYTE_W];
    assign o_cmd.sda_sample = s_axis_tdata[BYTE_W+1];

endmodule

// ===== rtl/i2cm_queue.sv =====
// ----------------------------------------------------------------------------
// i2cm_queue
// Short FIFO of classified ticks between the front and the bit engine.
// ----------------------------------------------------------------------------
module i2cm_queue
    import i2cm_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/i2cm_back.sv =====
// ----------------------------------------------------------------------------
// i2cm_back
// Bit engine: steps the bus phases one tick per item and registers the result.
// ----------------------------------------------------------------------------
module i2cm_back
    import i2cm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [HALF_W-1:0]    i_cfg_wr_data,
    input  t_cmd                 i_cmd,
    input  logic                 i_q_empty,
    output logic                 o_pop,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic [HALF_W-1:0]    r_half;
    t_phase               r_phase;
    logic [BIT_CNT_W-1:0] r_bit_cnt;
    logic [BYTE_W-1:0]    r_shift;
    logic [HALF_W-1:0]    r_tick;
    logic                 r_scl;
    logic                 r_sda;
    logic                 r_ack;
    logic [BYTE_W-1:0]    r_last_rx;
    logic                 r_out_valid;
    t_res                 r_out;

    t_phase               n_phase;
    logic [BIT_CNT_W-1:0] n_bit_cnt;
    logic [BYTE_W-1:0]    n_shift;
    logic [HALF_W-1:0]    n_tick;
    logic                 n_scl;
    logic                 n_sda;
    logic                 n_ack;
    logic [BYTE_W-1:0]    n_last_rx;
    logic                 n_done;
    logic [HALF_W-1:0]    half_eff;

    assign o_pop         = !i_q_empty && (!r_out_valid || m_axis_tready);
    assign half_eff      = (r_half == '0) ? HALF_W'(1) : r_half;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_out);

    always_comb begin
        n_phase   = r_phase;
        n_bit_cnt = r_bit_cnt;
        n_shift   = r_shift;
        n_tick    = r_tick;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_ack     = r_ack;
        n_last_rx = r_last_rx;
        n_done    = 1'b0;
        if (r_phase == PH_IDLE) begin
            case (i_cmd.req)
                REQ_START: begin
                    n_phase = PH_START_HI;
                    n_tick  = HALF_W'(1);
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                end
                REQ_STOP: begin
                    n_phase = PH_STOP_LOW;
                    n_tick  = HALF_W'(1);
                    n_scl   = 1'b0;
                    n_sda   = 1'b0;
                end
                REQ_WRITE: begin
                    n_shift   = i_cmd.tx_byte;
                    n_bit_cnt = '0;
                    n_phase   = PH_WR_LOW;
                    n_tick    = HALF_W'(1);
                    n_scl     = 1'b0;
                    n_sda     = i_cmd.tx_byte[BYTE_W-1];
                end
                REQ_READ: begin
                    n_shift   = '0;
                    n_bit_cnt = '0;
                    n_ack     = i_cmd.send_ack;
                    n_phase   = PH_RD_LOW;
                    n_tick    = HALF_W'(1);
                    n_scl     = 1'b0;
                    n_sda     = 1'b1;
                end
                REQ_WAIT_ACK: begin
                    n_phase = PH_WAIT_ACK;
                    n_tick  = HALF_W'(1);
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end else if (r_phase == PH_WAIT_ACK) begin
            if (!i_cmd.sda_sample) begin
                n_phase = PH_IDLE;
                n_tick  = '0;
                n_done  = 1'b1;
                n_scl   = 1'b0;
                n_sda   = 1'b1;
            end
        end else if (r_tick < half_eff) begin
            n_tick = r_tick + 1'b1;
        end else begin
            n_tick = HALF_W'(1);
            case (r_phase)
                PH_START_HI: begin
                    n_phase = PH_START_HOLD;
                    n_scl   = 1'b1;
                    n_sda   = 1'b0;
                end
                PH_START_HOLD: begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                    n_done  = 1'b1;
                    n_scl   = 1'b0;
                    n_sda   = 1'b0;
                end
                PH_STOP_LOW: begin
                    n_phase = PH_STOP_HI;
                    n_scl   = 1'b1;
                    n_sda   = 1'b0;
                end
                PH_STOP_HI: begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                    n_done  = 1'b1;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                end
                PH_WR_LOW: begin
                    n_phase = PH_WR_HIGH;
                    n_scl   = 1'b1;
                    n_sda   = r_shift[BYTE_W-1];
                end
                PH_WR_HIGH: begin
                    n_shift   = {r_shift[BYTE_W-2:0], 1'b0};
                    n_bit_cnt = r_bit_cnt + 1'b1;
                    n_scl     = 1'b0;
                    if (n_bit_cnt >= BITS_PER_BYTE) begin
                        n_phase = PH_IDLE;
                        n_tick  = '0;
                        n_done  = 1'b1;
                    end else begin
                        n_phase = PH_WR_LOW;
                        n_sda   = r_shift[BYTE_W-2];
                    end
                end
                PH_RD_LOW: begin
                    n_phase = PH_RD_HIGH;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                end
                PH_RD_HIGH: begin
                    n_shift   = {r_shift[BYTE_W-2:0], i_cmd.sda_sample};
                    n_bit_cnt = r_bit_cnt + 1'b1;
                    n_scl     = 1'b0;
                    if (n_bit_cnt >= BITS_PER_BYTE) begin
                        n_phase = PH_ACK_LOW;
                        n_sda   = !r_ack;
                    end else begin
                        n_phase = PH_RD_LOW;
                        n_sda   = 1'b1;
                    end
                end
                PH_ACK_LOW: begin
                    n_phase = PH_ACK_HIGH;
                    n_scl   = 1'b1;
                end
                PH_ACK_HIGH: begin
                    n_last_rx = r_shift;
                    n_phase   = PH_IDLE;
                    n_tick    = '0;
                    n_done    = 1'b1;
                    n_scl     = 1'b0;
                    n_sda     = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_PERIOD_RESET;
        end else if (i_cfg_wr_en) begin
            r_half <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_cnt   <= '0;
            r_shift     <= '0;
            r_tick      <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_ack       <= 1'b0;
            r_last_rx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_bit_cnt   <= n_bit_cnt;
                r_shift     <= n_shift;
                r_tick      <= n_tick;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_ack       <= n_ack;
                r_last_rx   <= n_last_rx;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.scl_level <= n_scl;
            r_out.sda_level <= n_sda;
            r_out.busy_res  <= (n_phase != PH_IDLE);
            r_out.cmd_done  <= n_done;
            r_out.rx_byte   <= n_last_rx;
        end
    end

endmodule

// ===== rtl/i2c_master_bit_engine_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// I2C master bit engine: one bus tick per stream item, one result per tick.
// ----------------------------------------------------------------------------
// Each input item is one tick of the bus sequencer and gives exactly one
// result item with the SCL and SDA drives, busy, a done pulse and the last
// read byte. With the result side ready, one item is taken every clock cycle.
// A result passes through the tick queue, is registered in the engine's
// output register and waits there until it is transferred. While the result
// side stalls, the two-entry tick queue fills and then holds the input.
// Phase lengths count ticks, not clock cycles, so the half period register
// sets bus timing only in items.
// Write the half period register only while the engine is idle.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit
    import i2cm_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [HALF_W-1:0]    i_cfg_wr_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tx_byte [7:0], send_ack [8], sda_sample [9], zero [15:10]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // req_type [2:0]
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // scl_level [0], sda_level [1], busy_res [2], cmd_done [3], rx_byte [11:4],
    // zero [15:12]
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    i2cm_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    i2cm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (queue_cmd),
        .i_q_empty     (q_empty),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== bench/i2c_master_bit_engine_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit_tb
// Self-checking bench for the I2C master bit engine.
// ----------------------------------------------------------------------------
// Streams bus ticks into the engine and predicts the SCL and SDA drives, busy,
// done pulse and read byte of every tick. Each result transfer is checked
// against the oldest prediction. Directed commands cover byte extremes,
// ACK/NACK, wait-for-ACK, ignored requests and half period extremes. Random
// start/write/read/stop sequences follow under several half periods. Both
// stream sides idle in random bursts, except in the closing test.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit_tb;

    import i2cm_pkg::*;

    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [HALF_W-1:0]    i_cfg_wr_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    t_phase              eng_phase;
    logic [BIT_CNT_W-1:0] eng_bits;
    logic [BYTE_W-1:0]   eng_shift;
    logic [HALF_W-1:0]   eng_ticks;
    logic [HALF_W-1:0]   eng_half;
    logic [BYTE_W-1:0]   eng_rx;
    logic                eng_scl;
    logic                eng_sda;
    logic                eng_ack;
    logic                eng_done;

    t_res expected_levels_q[$];
    int   fail_cnt;
    int   ticks_sent;
    bit   idling_on;

    i2c_master_bit_engine_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void enter_phase(input t_phase nxt, input logic scl, input logic sda);
        eng_phase = nxt;
        eng_ticks = 8'd1;
        eng_scl   = scl;
        eng_sda   = sda;
    endfunction

    function automatic void finish_cmd(input logic scl, input logic sda);
        eng_phase = PH_IDLE;
        eng_ticks = '0;
        eng_done  = 1'b1;
        eng_scl   = scl;
        eng_sda   = sda;
    endfunction

    function automatic void predict_bus_tick(input logic [REQ_W-1:0] req,
                                             input logic [BYTE_W-1:0] tx,
                                             input logic ack, input logic sda_in);
        logic [HALF_W-1:0] h;
        t_res              r;
        h        = (eng_half == '0) ? 8'd1 : eng_half;
        eng_done = 1'b0;
        if (eng_phase == PH_IDLE) begin
            case (req)
                REQ_START:    enter_phase(PH_START_HI, 1'b1, 1'b1);
                REQ_STOP:     enter_phase(PH_STOP_LOW, 1'b0, 1'b0);
                REQ_WRITE: begin
                    eng_shift = tx;
                    eng_bits  = '0;
                    enter_phase(PH_WR_LOW, 1'b0, tx[7]);
                end
                REQ_READ: begin
                    eng_shift = '0;
                    eng_bits  = '0;
                    eng_ack   = ack;
                    enter_phase(PH_RD_LOW, 1'b0, 1'b1);
                end
                REQ_WAIT_ACK: enter_phase(PH_WAIT_ACK, 1'b1, 1'b1);
                default: ;
            endcase
        end else if (eng_phase == PH_WAIT_ACK) begin
            if (!sda_in)
                finish_cmd(1'b0, 1'b1);
        end else if (eng_ticks < h) begin
            eng_ticks = eng_ticks + 8'd1;
        end else begin
            case (eng_phase)
                PH_START_HI:   enter_phase(PH_START_HOLD, 1'b1, 1'b0);
                PH_START_HOLD: finish_cmd(1'b0, 1'b0);
                PH_STOP_LOW:   enter_phase(PH_STOP_HI, 1'b1, 1'b0);
                PH_STOP_HI:    finish_cmd(1'b1, 1'b1);
                PH_WR_LOW:     enter_phase(PH_WR_HIGH, 1'b1, eng_shift[7]);
                PH_WR_HIGH: begin
                    eng_shift = eng_shift << 1;
                    eng_bits  = eng_bits + 4'd1;
                    if (eng_bits >= BITS_PER_BYTE)
                        finish_cmd(1'b0, eng_sda);
                    else
                        enter_phase(PH_WR_LOW, 1'b0, eng_shift[7]);
                end
                PH_RD_LOW:     enter_phase(PH_RD_HIGH, 1'b1, 1'b1);
                PH_RD_HIGH: begin
                    eng_shift = {eng_shift[6:0], sda_in};
                    eng_bits  = eng_bits + 4'd1;
                    if (eng_bits >= BITS_PER_BYTE)
                        enter_phase(PH_ACK_LOW, 1'b0, !eng_ack);
                    else
                        enter_phase(PH_RD_LOW, 1'b0, 1'b1);
                end
                PH_ACK_LOW:    enter_phase(PH_ACK_HIGH, 1'b1, eng_sda);
                PH_ACK_HIGH: begin
                    eng_rx = eng_shift;
                    finish_cmd(1'b0, 1'b1);
                end
                default: begin
                    eng_phase = PH_IDLE;
                    eng_ticks = '0;
                end
            endcase
        end
        r.scl_level = eng_scl;
        r.sda_level = eng_sda;
        r.busy_res  = (eng_phase != PH_IDLE);
        r.cmd_done  = eng_done;
        r.rx_byte   = eng_rx;
        expected_levels_q.push_back(r);
    endfunction

    task automatic send_tick(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] tx,
                             input logic ack, input logic sda_in);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, sda_in, ack, tx};
        s_axis_tuser  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_bus_tick(req, tx, ack, sda_in);
        ticks_sent++;
    endtask

    task automatic run_command(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] tx,
                               input logic ack, input int sda_high_pct);
        while (eng_phase != PH_IDLE)
            send_tick(REQ_W'($urandom_range(0, 7)), BYTE_W'($urandom), 1'($urandom),
                      1'($urandom_range(0, 1)));
        send_tick(req, tx, ack, 1'($urandom_range(0, 1)));
        while (eng_phase != PH_IDLE)
            send_tick(REQ_W'($urandom_range(0, 7)), BYTE_W'($urandom), 1'($urandom),
                      $urandom_range(1, 100) <= sda_high_pct);
    endtask

    task automatic settle_engine();
        while (eng_phase != PH_IDLE)
            send_tick(REQ_NONE, BYTE_W'($urandom), 1'($urandom), 1'b0);
        s_axis_tvalid <= 1'b0;
        while (expected_levels_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_half_period(input logic [HALF_W-1:0] val);
        settle_engine();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        eng_half = val;
    endtask

    task automatic run_transaction();
        int n;
        run_command(REQ_START, BYTE_W'($urandom), 1'($urandom), 50);
        n = $urandom_range(1, 3);
        repeat (n) run_command(REQ_WRITE, BYTE_W'($urandom), 1'($urandom), 50);
        n = $urandom_range(0, 2);
        repeat (n) run_command(REQ_READ, BYTE_W'($urandom), 1'($urandom),
                               $urandom_range(0, 100));
        if ($urandom_range(0, 1))
            run_command(REQ_WAIT_ACK, BYTE_W'($urandom), 1'($urandom),
                        $urandom_range(20, 80));
        run_command(REQ_STOP, BYTE_W'($urandom), 1'($urandom), 50);
    endtask

    task automatic test_idle_requests();
        repeat (3) begin
            send_tick(REQ_NONE, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
            send_tick(REQ_SPARE_6, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
            send_tick(REQ_SPARE_7, BYTE_W'($urandom), 1'($urandom), 1'($urandom));
        end
        run_command(REQ_START, 8'h00, 1'b0, 50);
    endtask

    task automatic test_byte_extremes();
        write_half_period(8'd1);
        run_command(REQ_START, 8'h00, 1'b0, 50);
        run_command(REQ_WRITE, 8'h00, 1'b0, 50);
        run_command(REQ_WRITE, 8'hFF, 1'b1, 50);
        run_command(REQ_WRITE, 8'h80, 1'b0, 50);
        run_command(REQ_WRITE, 8'h01, 1'b1, 50);
        run_command(REQ_READ, 8'h00, 1'b1, 100);
        run_command(REQ_READ, 8'hFF, 1'b0, 0);
        run_command(REQ_READ, 8'h5A, 1'b1, 50);
        run_command(REQ_WAIT_ACK, 8'h00, 1'b0, 80);
        run_command(REQ_STOP, 8'h00, 1'b0, 50);
    endtask

    task automatic test_half_period_zero();
        write_half_period(8'd0);
        run_command(REQ_START, BYTE_W'($urandom), 1'($urandom), 50);
        run_command(REQ_WRITE, BYTE_W'($urandom), 1'($urandom), 50);
        run_command(REQ_READ, BYTE_W'($urandom), 1'b0, 50);
        run_command(REQ_STOP, BYTE_W'($urandom), 1'($urandom), 50);
    endtask

    task automatic test_half_period_max();
        write_half_period(8'd255);
        run_command(REQ_START, BYTE_W'($urandom), 1'($urandom), 50);
    endtask

    task automatic test_random_traffic();
        logic [HALF_W-1:0] half_set[5];
        int                start_ticks;
        half_set = '{8'd1, 8'd2, 8'd1, 8'($urandom_range(1, 3)), 8'd1};
        foreach (half_set[i]) begin
            write_half_period(half_set[i]);
            start_ticks = ticks_sent;
            while (ticks_sent - start_ticks < 40) begin
                if ($urandom_range(0, 9) == 0)
                    send_tick(REQ_W'($urandom_range(0, 7)), BYTE_W'($urandom),
                              1'($urandom), 1'($urandom));
                else
                    run_transaction();
            end
        end
    endtask

    task automatic test_back_to_back();
        write_half_period(8'd1);
        idling_on = 1'b0;
        repeat (2) run_transaction();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        eng_phase  = PH_IDLE;
        eng_bits   = '0;
        eng_shift  = '0;
        eng_ticks  = '0;
        eng_half   = HALF_PERIOD_RESET;
        eng_rx     = '0;
        eng_scl    = 1'b1;
        eng_sda    = 1'b1;
        eng_ack    = 1'b0;
        eng_done   = 1'b0;
        fail_cnt   = 0;
        ticks_sent = 0;
        idling_on  = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_requests();
        test_byte_extremes();
        test_half_period_zero();
        test_half_period_max();
        test_random_traffic();
        test_back_to_back();
        settle_engine();
        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stall the result side in random bursts
    initial begin
        m_axis_tready <= 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (idling_on && $urandom_range(0, 9) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[11:0];
            if (expected_levels_q.size() == 0) begin
                $error("result transfer with no prediction pending: %h", m_axis_tdata);
                fail_cnt++;
            end else begin
                want = expected_levels_q.pop_front();
                if (got.scl_level !== want.scl_level) begin
                    $error("scl_level: expected %0d, got %0d", want.scl_level, got.scl_level);
                    fail_cnt++;
                end
                if (got.sda_level !== want.sda_level) begin
                    $error("sda_level: expected %0d, got %0d", want.sda_level, got.sda_level);
                    fail_cnt++;
                end
                if (got.busy_res !== want.busy_res) begin
                    $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
                    fail_cnt++;
                end
                if (got.cmd_done !== want.cmd_done) begin
                    $error("cmd_done: expected %0d, got %0d", want.cmd_done, got.cmd_done);
                    fail_cnt++;
                end
                if (got.rx_byte !== want.rx_byte) begin
                    $error("rx_byte: expected %h, got %h", want.rx_byte, got.rx_byte);
                    fail_cnt++;
                end
            end
        end
    end

endmodule

// ===== filelist.f =====
rtl/i2cm_pkg.sv
rtl/i2cm_front.sv
rtl/i2cm_queue.sv
rtl/i2cm_back.sv
rtl/i2c_master_bit_engine_unit.sv
bench/i2c_master_bit_engine_unit_tb.sv
